@@ hdl/tps_pkg.sv @@
// Shared constants and control types of the task priority scheduler.
package tps_pkg;

  localparam int MaxTasks  = 16;
  localparam int IdxW      = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW      = $clog2(MaxTasks + 1);
  localparam int BurstW    = 10;
  localparam int KeyW      = 14;
  localparam int TimeW     = 14;
  localparam int TaskIdxW  = 4;
  localparam int EntryW    = BurstW + KeyW;

  localparam logic [KeyW-1:0]  KeyLimit = KeyW'(9999);
  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted request
    logic scan_start;  // begin a minimum-key scan over the loaded tasks
    logic commit;      // retire the scan winner into the pending result
    logic clear;       // end of run: drop the task set and the time base
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_busy;
    logic found;
  } dp_status_t;

endpackage

@@ hdl/tps_if.sv @@
// Channel interfaces of the task priority scheduler.
interface tps_req_if;
  logic                          valid;
  logic                          ready;
  logic [tps_pkg::BurstW-1:0]    burst_time;
  logic [tps_pkg::KeyW-1:0]      task_deadline;
  logic [tps_pkg::KeyW-1:0]      task_period;
  logic                          last_task;

  modport source (output valid, burst_time, task_deadline, task_period, last_task,
                  input ready);
  modport sink   (input valid, burst_time, task_deadline, task_period, last_task,
                  output ready);
endinterface

interface tps_res_if;
  logic                          valid;
  logic                          ready;
  logic [tps_pkg::TaskIdxW-1:0]  task_index;
  logic [tps_pkg::TimeW-1:0]     completion_time;
  logic [tps_pkg::TimeW-1:0]     waiting_time;
  logic                          last_result;

  modport source (output valid, task_index, completion_time, waiting_time, last_result,
                  input ready);
  modport sink   (input valid, task_index, completion_time, waiting_time, last_result,
                  output ready);
endinterface

interface tps_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/tps_dp.sv @@
// Datapath: task store, minimum-key scan, time base and pending result.
module tps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tps_pkg::ctrl_cmd_t            cmd_i,
  output tps_pkg::dp_status_t           status_o,
  input  logic                          priority_rule_i,
  input  logic [tps_pkg::BurstW-1:0]    burst_time_i,
  input  logic [tps_pkg::KeyW-1:0]      task_deadline_i,
  input  logic [tps_pkg::KeyW-1:0]      task_period_i,
  output logic [tps_pkg::TaskIdxW-1:0]  task_index_o,
  output logic [tps_pkg::TimeW-1:0]     completion_time_o,
  output logic [tps_pkg::TimeW-1:0]     waiting_time_o
);

  // Task memory: burst in the upper bits, key in the lower bits.
  logic [tps_pkg::EntryW-1:0] mem [tps_pkg::MaxTasks];

  logic [tps_pkg::MaxTasks-1:0] done_q, done_d;
  logic [tps_pkg::CntW-1:0]     count_q, count_d;
  logic [tps_pkg::CntW-1:0]     ptr_q, ptr_d;
  logic                         busy_q, busy_d;
  logic                         rd_v_q, rd_v_d;
  logic [tps_pkg::IdxW-1:0]     rd_idx_q;
  logic                         rd_done_q;
  logic [tps_pkg::EntryW-1:0]   rd_data_q;
  logic                         best_v_q, best_v_d;
  logic [tps_pkg::KeyW-1:0]     best_key_q, best_key_d;
  logic [tps_pkg::IdxW-1:0]     best_idx_q, best_idx_d;
  logic [tps_pkg::BurstW-1:0]   best_burst_q, best_burst_d;
  logic [tps_pkg::TimeW-1:0]    elapsed_q, elapsed_d;
  logic [tps_pkg::IdxW-1:0]     pend_idx_q;
  logic [tps_pkg::TimeW-1:0]    pend_ct_q;
  logic [tps_pkg::TimeW-1:0]    pend_wt_q;

  logic                         issue;
  logic [tps_pkg::BurstW-1:0]   rd_burst;
  logic [tps_pkg::KeyW-1:0]     rd_key;
  logic [tps_pkg::TimeW:0]      sum;
  logic [tps_pkg::TimeW-1:0]    finish;
  logic [tps_pkg::KeyW-1:0]     new_key;

  assign issue    = busy_q && (ptr_q < count_q);
  assign rd_burst = rd_data_q[tps_pkg::EntryW-1 -: tps_pkg::BurstW];
  assign rd_key   = rd_data_q[tps_pkg::KeyW-1:0];
  assign sum      = {1'b0, elapsed_q} + (tps_pkg::TimeW+1)'(best_burst_q);
  assign finish   = sum[tps_pkg::TimeW] ? tps_pkg::TimeMax : sum[tps_pkg::TimeW-1:0];
  assign new_key  = priority_rule_i ? task_period_i : task_deadline_i;

  always_comb begin
    done_d       = done_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    busy_d       = busy_q;
    rd_v_d       = issue;
    best_v_d     = best_v_q;
    best_key_d   = best_key_q;
    best_idx_d   = best_idx_q;
    best_burst_d = best_burst_q;
    elapsed_d    = elapsed_q;

    if (issue) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (rd_v_q && !rd_done_q && (rd_key < best_key_q)) begin
      best_v_d     = 1'b1;
      best_key_d   = rd_key;
      best_idx_d   = rd_idx_q;
      best_burst_d = rd_burst;
    end
    if (busy_q && !issue && !rd_v_q) begin
      busy_d = 1'b0;
    end

    if (cmd_i.load && (count_q < tps_pkg::CntW'(tps_pkg::MaxTasks))) begin
      done_d[count_q[tps_pkg::IdxW-1:0]] = 1'b0;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.commit) begin
      done_d[best_idx_q] = 1'b1;
      elapsed_d          = finish;
    end
    if (cmd_i.clear) begin
      done_d    = '0;
      count_d   = '0;
      elapsed_d = '0;
    end
    if (cmd_i.scan_start) begin
      busy_d     = 1'b1;
      ptr_d      = '0;
      rd_v_d     = 1'b0;
      best_v_d   = 1'b0;
      best_key_d = tps_pkg::KeyLimit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      count_q   <= '0;
      ptr_q     <= '0;
      busy_q    <= 1'b0;
      rd_v_q    <= 1'b0;
      best_v_q  <= 1'b0;
      elapsed_q <= '0;
    end else begin
      done_q    <= done_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      busy_q    <= busy_d;
      rd_v_q    <= rd_v_d;
      best_v_q  <= best_v_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Payload registers and the task memory carry no reset.
  always_ff @(posedge clk_i) begin
    best_key_q   <= best_key_d;
    best_idx_q   <= best_idx_d;
    best_burst_q <= best_burst_d;
    if (cmd_i.load && (count_q < tps_pkg::CntW'(tps_pkg::MaxTasks))) begin
      mem[count_q[tps_pkg::IdxW-1:0]] <= {burst_time_i, new_key};
    end
    if (issue) begin
      rd_data_q <= mem[ptr_q[tps_pkg::IdxW-1:0]];
      rd_idx_q  <= ptr_q[tps_pkg::IdxW-1:0];
      rd_done_q <= done_q[ptr_q[tps_pkg::IdxW-1:0]];
    end
    if (cmd_i.commit) begin
      pend_idx_q <= best_idx_q;
      pend_ct_q  <= finish;
      pend_wt_q  <= finish - tps_pkg::TimeW'(best_burst_q);
    end
  end

  assign status_o.scan_busy = busy_q;
  assign status_o.found     = best_v_q;
  assign task_index_o       = tps_pkg::TaskIdxW'(pend_idx_q);
  assign completion_time_o  = pend_ct_q;
  assign waiting_time_o     = pend_wt_q;

endmodule

@@ hdl/tps_ctrl.sv @@
// Controller: sequences loading, scans and result delivery.
module tps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 req_last_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic                 res_last_o,
  input  tps_pkg::dp_status_t  status_i,
  output tps_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_MID,
    ST_EMIT_LAST
  } state_e;

  state_e state_q, state_d;
  logic   pend_v_q, pend_v_d;

  always_comb begin
    state_d     = state_q;
    pend_v_d    = pend_v_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_last_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          if (req_last_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!status_i.scan_busy) begin
          priority if (status_i.found && pend_v_q) begin
            state_d = ST_EMIT_MID;
          end else if (status_i.found) begin
            cmd_o.commit     = 1'b1;
            cmd_o.scan_start = 1'b1;
            pend_v_d         = 1'b1;
          end else if (pend_v_q) begin
            state_d = ST_EMIT_LAST;
          end else begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      ST_EMIT_MID: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cmd_o.commit     = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_EMIT_LAST: begin
        res_valid_o = 1'b1;
        res_last_o  = 1'b1;
        if (res_ready_i) begin
          cmd_o.clear = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
    end
  end

endmodule

@@ hdl/task_priority_scheduler.sv @@
// Top level: non-preemptive EDF / rate-monotonic task scheduler.
// A request without the last flag is stored and the block stays ready for another request.
// A run makes one minimum-key scan over the N loaded tasks per scheduled task (one memory read
// per cycle in the scan), and each result waits for its handshake; the first result appears
// after two scans. Requests are taken one at a time, only while no run is in progress.
// Reset clears the task count, the completion flags, the time base and the priority rule.
module task_priority_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  tps_req_if.sink    sched_req,
  tps_res_if.source  sched_res,
  tps_cfg_if.sink    cfg_wr
);

  // The priority rule register is always writable; it is sampled when each task is
  // stored, so every task keeps the key chosen at load time.
  logic priority_rule_q;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priority_rule_q <= 1'b0;
    end else if (cfg_wr.valid) begin
      priority_rule_q <= cfg_wr.data;
    end
  end

  tps_pkg::ctrl_cmd_t  cmd;
  tps_pkg::dp_status_t status;

  // The controller holds one result back until the following scan shows whether another
  // task remains, so that the final result of a run can carry the last flag.
  tps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (sched_req.valid),
    .req_ready_o (sched_req.ready),
    .req_last_i  (sched_req.last_task),
    .res_valid_o (sched_res.valid),
    .res_ready_i (sched_res.ready),
    .res_last_o  (sched_res.last_result),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath keeps the task memory, scans it for the smallest key below the limit,
  // advances the saturating time base and holds the pending result registers that drive
  // the result channel.
  tps_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .priority_rule_i   (priority_rule_q),
    .burst_time_i      (sched_req.burst_time),
    .task_deadline_i   (sched_req.task_deadline),
    .task_period_i     (sched_req.task_period),
    .task_index_o      (sched_res.task_index),
    .completion_time_o (sched_res.completion_time),
    .waiting_time_o    (sched_res.waiting_time)
  );

endmodule

@@ hdl/tps_checker.sv @@
// Port-level checker of the task priority scheduler and its bind.
module tps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          req_last_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [tps_pkg::TaskIdxW-1:0]  res_index_i,
  input logic [tps_pkg::TimeW-1:0]     res_ct_i,
  input logic [tps_pkg::TimeW-1:0]     res_wt_i,
  input logic                          res_last_i
);

  // No request is taken while a result is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_i && req_ready_i))
    else $error("request accepted while a result is offered");

  // A stored task that does not close the set produces no result.
  a_quiet_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && !req_last_i) |=> !res_valid_i)
    else $error("result after a request without the last flag");

  // Waiting time never exceeds completion time.
  a_wait_le_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_wt_i <= res_ct_i))
    else $error("waiting time above completion time");

  // A stalled result holds its payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(res_index_i) && $stable(res_ct_i) && $stable(res_wt_i) &&
       $stable(res_last_i)))
    else $error("stalled result changed");

endmodule

bind task_priority_scheduler tps_checker u_tps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (sched_req.valid),
  .req_ready_i (sched_req.ready),
  .req_last_i  (sched_req.last_task),
  .res_valid_i (sched_res.valid),
  .res_ready_i (sched_res.ready),
  .res_index_i (sched_res.task_index),
  .res_ct_i    (sched_res.completion_time),
  .res_wt_i    (sched_res.waiting_time),
  .res_last_i  (sched_res.last_result)
);
